// File: hdl/csta_pkg.sv
// Package for the client slot table with aging.
// Holds field widths, parameter defaults, register indexes, the sequencer state type
// and the configuration bundle passed from the register block to the scan engine.
package csta_pkg;

    localparam int NUM_SLOTS_DEF       = 8;
    localparam int FIRST_AGED_SLOT_DEF = 1;

    localparam int ID_W       = 15;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int SLOT_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_W-1:0] LOCAL_ID_RST = 16'h8000;
    localparam logic [CFG_W-1:0] EXPIRY_RST   = 16'd10;

    // Register index, taken from paddr[2].
    localparam logic REG_LOCAL_ID = 1'b0;
    localparam logic REG_EXPIRY   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             local_wr;
        logic             local_set;
        logic [ID_W-1:0]  local_owner;
        logic [CFG_W-1:0] expiry;
    } t_cfg;

endpackage

// File: hdl/csta_cfg.sv
// APB-style configuration registers for the client slot table.
// Depends on csta_pkg; hands a t_cfg bundle to the scan engine.
module csta_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csta_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csta_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csta_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output csta_pkg::t_cfg                  o_cfg
);
    import csta_pkg::*;

    logic [CFG_W-1:0] r_local_id;
    logic [CFG_W-1:0] r_expiry;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_id <= LOCAL_ID_RST;
            r_expiry   <= EXPIRY_RST;
        end else if (wr_en) begin
            if (reg_idx == REG_LOCAL_ID) begin
                r_local_id <= pwdata[CFG_W-1:0];
            end else begin
                r_expiry <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_LOCAL_ID) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_local_id};
        end else begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_expiry};
        end
    end

    // A write of the local id takes effect on slot 0 at the same edge.
    always_comb begin
        o_cfg.local_wr    = wr_en && (reg_idx == REG_LOCAL_ID);
        o_cfg.local_set   = !pwdata[CFG_W-1];
        o_cfg.local_owner = pwdata[ID_W-1:0];
        o_cfg.expiry      = r_expiry;
    end

endmodule

// File: hdl/csta_scan.sv
// Scan engine of the client slot table: valid bits, owner and time memories, sequencer.
// Depends on csta_pkg; driven by the t_cfg bundle from csta_cfg.
module csta_scan #(
    parameter int NUM_SLOTS       = csta_pkg::NUM_SLOTS_DEF,
    parameter int FIRST_AGED_SLOT = csta_pkg::FIRST_AGED_SLOT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  csta_pkg::t_cfg              i_cfg,
    input  logic                        start,
    input  logic [csta_pkg::ID_W-1:0]   i_client_id,
    input  logic [csta_pkg::TIME_W-1:0] i_now,
    output logic                        busy,
    output logic                        o_done,
    output logic [csta_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_no_slot
);
    import csta_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(FIRST_AGED_SLOT);

    t_state r_state;
    t_state n_state;

    logic [NUM_SLOTS-1:0] r_valid;
    logic [ID_W-1:0]      r_owner_mem [NUM_SLOTS];
    logic [TIME_W-1:0]    r_time_mem  [NUM_SLOTS];

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now;
    logic              r_rd_on;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_chk_on;
    logic [IDX_W-1:0]  r_chk_idx;
    logic [ID_W-1:0]   r_owner_q;
    logic [TIME_W-1:0] r_time_q;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_has_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_done;
    logic [SLOT_W-1:0] r_slot;
    logic              r_no_slot;

    logic                    accept;
    logic                    do_write;
    logic [TIME_W-1:0]       age;
    logic                    expired;
    logic                    live;
    logic                    is_match;
    logic                    is_empty;
    logic                    claim;
    logic [IDX_W-1:0]        sel_idx;
    logic [IDX_W+SLOT_W-1:0] sel_ext;
    logic                    owner_we;
    logic [IDX_W-1:0]        owner_waddr;
    logic [ID_W-1:0]         owner_wdata;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_chk_on && (r_chk_idx == LAST_IDX)) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        busy     = 1'b1;
        do_write = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                busy = 1'b1;
            end
            ST_DONE: begin
                do_write = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read address walk and the check pointer, a registered copy of the read address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_on   <= 1'b0;
            r_rd_idx  <= '0;
            r_chk_on  <= 1'b0;
            r_chk_idx <= '0;
        end else begin
            r_chk_on  <= r_rd_on;
            r_chk_idx <= r_rd_idx;
            if (accept) begin
                r_rd_on  <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_rd_on) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_on <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id  <= i_client_id;
            r_now <= i_now;
        end
    end

    // Synchronous reads, registered into r_owner_q and r_time_q.
    always_ff @(posedge i_clk) begin
        if (r_rd_on) begin
            r_owner_q <= r_owner_mem[r_rd_idx];
            r_time_q  <= r_time_mem[r_rd_idx];
        end
    end

    // Per-slot check: age out first, then look for a match or an empty slot.
    always_comb begin
        age      = r_now - r_time_q;
        expired  = r_valid[r_chk_idx] && (r_chk_idx >= FIRST_IDX)
                   && (age > {{(TIME_W-CFG_W){1'b0}}, i_cfg.expiry});
        live     = r_valid[r_chk_idx] && !expired;
        is_match = r_chk_on && live && (r_owner_q == r_id);
        is_empty = r_chk_on && !live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_has_free <= 1'b0;
        end else if (accept) begin
            r_hit      <= 1'b0;
            r_has_free <= 1'b0;
        end else begin
            if (is_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_chk_idx;
            end
            if (is_empty && !r_has_free) begin
                r_has_free <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
        end
    end

    assign claim   = do_write && !r_hit && r_has_free;
    assign sel_idx = r_hit ? r_hit_idx : r_free_idx;
    assign sel_ext = {{SLOT_W{1'b0}}, sel_idx};

    // Valid bits: aging clears and claims never coincide; keeping the local id load apart from both is up to the user.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cfg.local_wr) r_valid[0] <= i_cfg.local_set;
            if (r_chk_on && expired) r_valid[r_chk_idx] <= 1'b0;
            if (claim) r_valid[r_free_idx] <= 1'b1;
        end
    end

    // Write-back happens only after the whole scan, so no read can overlap it.
    always_comb begin
        owner_we    = claim || (i_cfg.local_wr && i_cfg.local_set);
        owner_waddr = claim ? r_free_idx : '0;
        owner_wdata = claim ? r_id : i_cfg.local_owner;
    end

    always_ff @(posedge i_clk) begin
        if (owner_we) r_owner_mem[owner_waddr] <= owner_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (do_write && (r_hit || r_has_free)) r_time_mem[sel_idx] <= r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_no_slot <= !r_hit && !r_has_free;
            r_slot    <= (r_hit || r_has_free) ? sel_ext[SLOT_W-1:0] : '0;
        end
    end

    assign o_done    = r_done;
    assign o_slot    = r_slot;
    assign o_no_slot = r_no_slot;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_done_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("engine went idle without a result");

    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_no_slot) |-> (o_slot == '0))
        else $error("slot not zero with no_slot set");

    a_check_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_on |-> (r_state == ST_SCAN))
        else $error("slot check outside of scan");

endmodule

// File: hdl/client_slot_table_with_aging.sv
// Top level of the client slot table with aging.
// Depends on csta_pkg, csta_cfg and csta_scan.
//
// A request is taken when start is high and busy is low. The engine then walks all
// NUM_SLOTS entries of its owner and time memories, one read per cycle through a
// single synchronous read port, ages each slot and notes the first matching and the
// first empty slot, and writes the refreshed or claimed entry back in a final
// write-back state. Busy stays high through the scan and the write-back state and
// then drops; a request is taken only while the engine is idle, so a new request
// cannot be taken before the last one is through. The result beat appears on
// o_slot and o_no_slot with o_done high for exactly one cycle, in the same cycle in
// which busy falls; the receiver cannot stall it, so it must take the beat in that
// cycle.
// Because write-back follows the complete scan, no read ever races a pending write.
// Configuration is written through the APB port: the local id at address 0 (bit 15
// clear loads slot 0 with the low 15 bits, bit 15 set empties slot 0) and the expiry
// in seconds at address 4. Write configuration only while the block is idle. Every
// slot is empty after reset, and no clearing pass is needed.
module client_slot_table_with_aging #(
    parameter int NUM_SLOTS       = csta_pkg::NUM_SLOTS_DEF,
    parameter int FIRST_AGED_SLOT = csta_pkg::FIRST_AGED_SLOT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csta_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [csta_pkg::APB_DATA_W-1:0] pwdata,
    output logic [csta_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [csta_pkg::ID_W-1:0]       i_client_id,
    input  logic [csta_pkg::TIME_W-1:0]     i_now,
    output logic                            o_done,
    output logic [csta_pkg::SLOT_W-1:0]     o_slot,
    output logic                            o_no_slot
);
    import csta_pkg::*;

    // Configuration bundle: local id load pulse and the current expiry setting.
    t_cfg cfg;

    csta_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The scan engine holds all slot state and produces one result beat per request.
    csta_scan #(
        .NUM_SLOTS       (NUM_SLOTS),
        .FIRST_AGED_SLOT (FIRST_AGED_SLOT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .start       (start),
        .i_client_id (i_client_id),
        .i_now       (i_now),
        .busy        (busy),
        .o_done      (o_done),
        .o_slot      (o_slot),
        .o_no_slot   (o_no_slot)
    );

endmodule

// File: sim/tb_client_slot_table_with_aging.sv
`timescale 1ns / 1ps
// Self-checking testbench for the client slot table with aging.
// Depends on csta_pkg and client_slot_table_with_aging; it predicts every slot grant
// in its own model of the table and checks each result beat against it or a directed grant.
module tb_client_slot_table_with_aging;
    import csta_pkg::*;

    localparam int SLOTS       = NUM_SLOTS_DEF;
    localparam int FIRST_AGED  = FIRST_AGED_SLOT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    // Cycles let pass after the last result before a register write or the verdict.
    localparam int SETTLE      = SLOTS + 8;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 100;
    localparam int DIR_ROWS    = 26;

    localparam logic [APB_ADDR_W-1:0] ADDR_LOCAL_ID = {REG_LOCAL_ID, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_EXPIRY   = {REG_EXPIRY, 2'b00};

    // What a row of the directed table does.
    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_LOCAL,
        ROW_EXPIRY
    } t_row_kind;

    // One slot grant as the block reports it.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              no_slot;
    } t_grant;

    // A directed row: a request (arg is the client id) or a register write (arg is
    // the value). The grant fields count only where known is set.
    typedef struct packed {
        t_row_kind         kind;
        logic [31:0]       arg;
        logic [TIME_W-1:0] now;
        logic              known;
        logic [SLOT_W-1:0] slot;
        logic              no_slot;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [ID_W-1:0]       i_client_id = '0;
    logic [TIME_W-1:0]     i_now       = '0;
    logic                  o_done;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_no_slot;

    // Shadow of the table and of the two registers, kept in step with every
    // accepted request and every register write.
    logic              tbl_valid [SLOTS];
    logic [ID_W-1:0]   tbl_owner [SLOTS];
    logic [TIME_W-1:0] tbl_seen  [SLOTS];
    logic [CFG_W-1:0]  local_id_reg = LOCAL_ID_RST;
    logic [CFG_W-1:0]  expiry_reg   = EXPIRY_RST;

    t_grant grants_due [$];
    t_grant beat_want;
    t_row   dir_rows [DIR_ROWS];
    int     fail_count = 0;
    int     cycle_count = 0;

    client_slot_table_with_aging #(
        .NUM_SLOTS       (SLOTS),
        .FIRST_AGED_SLOT (FIRST_AGED)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_client_id (i_client_id),
        .i_now       (i_now),
        .o_done      (o_done),
        .o_slot      (o_slot),
        .o_no_slot   (o_no_slot)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_owner[i] = '0;
            tbl_seen[i]  = '0;
        end
    end

    // Grant prediction for one request. Aging comes first and never touches the
    // slots below FIRST_AGED, so a protected slot 0 survives any age. The age is the
    // wrapping 32-bit distance from the stored time. Then the lowest occupied slot
    // of this id wins and is refreshed; failing that the lowest empty slot is
    // claimed; a full table without the id gives no slot.
    function automatic t_grant assign_slot(input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] now);
        t_grant            g;
        logic [TIME_W-1:0] age;
        bit                placed;
        g.slot    = '0;
        g.no_slot = 1'b1;
        placed    = 1'b0;
        for (int i = FIRST_AGED; i < SLOTS; i++) begin
            age = now - tbl_seen[i];
            if (tbl_valid[i] && age > TIME_W'(expiry_reg)) begin
                tbl_valid[i] = 1'b0;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!placed && tbl_valid[i] && tbl_owner[i] == id) begin
                tbl_seen[i] = now;
                g.slot      = SLOT_W'(i);
                g.no_slot   = 1'b0;
                placed      = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_owner[i] = id;
                tbl_seen[i]  = now;
                g.slot       = SLOT_W'(i);
                g.no_slot    = 1'b0;
                placed       = 1'b1;
            end
        end
        return g;
    endfunction

    // Presents one request and holds it until the block accepts it. The
    // expectation is queued at the accepting edge, long before its result shows.
    // A typed grant from the directed table replaces the prediction, but the
    // shadow table is updated either way.
    task automatic send_request(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now,
                                input logic known, input t_grant typed_grant);
        t_grant g;
        start       <= 1'b1;
        i_client_id <= id;
        i_now       <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
        g = assign_slot(id, now);
        grants_due.push_back(known ? typed_grant : g);
    endtask

    // Random idle burst on the request side. Half of the bursts start only once the
    // block has gone idle, so gaps land both inside and after the scan.
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 99) < 35) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy !== 1'b0);
            end
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Stops requests and waits until every expected grant has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // APB write followed directly by a read of the same register. psel stays high,
    // and the setup cycle of the read comes right after the write access.
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        logic [CFG_W-1:0] mirror;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ADDR_LOCAL_ID) begin
            local_id_reg = value[CFG_W-1:0];
            mirror       = local_id_reg;
            // Bit 15 set empties slot 0; clear loads it without touching its time.
            if (local_id_reg[15]) begin
                tbl_valid[0] = 1'b0;
            end else begin
                tbl_valid[0] = 1'b1;
                tbl_owner[0] = local_id_reg[ID_W-1:0];
            end
        end else begin
            expiry_reg = value[CFG_W-1:0];
            mirror     = expiry_reg;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(mirror)) begin
            $error("prdata: expected %h, actual %h", APB_DATA_W'(mirror), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker. The receiver cannot stall, so every cycle with o_done high is
    // a beat and is matched against the oldest expected grant.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (grants_due.size() == 0) begin
                $error("unexpected result beat: slot %0d, no_slot %0b", o_slot, o_no_slot);
                fail_count++;
            end else begin
                beat_want = grants_due.pop_front();
                if (o_slot !== beat_want.slot) begin
                    $error("slot: expected %0d, actual %0d", beat_want.slot, o_slot);
                    fail_count++;
                end
                if (o_no_slot !== beat_want.no_slot) begin
                    $error("no_slot: expected %0b, actual %0b", beat_want.no_slot, o_no_slot);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] cur_now;
        logic [TIME_W-1:0] step;
        logic [ID_W-1:0]   id_pool [16];
        logic [31:0]       new_local;
        logic [31:0]       new_expiry;
        int                pool_n;
        int                pick;

        // Directed table. Right after reset the expiry is 10 and slot 0 is empty.
        // The first rows fill the table, probe the age boundary (exactly the expiry
        // stays, one more second goes), hit a full table, and then show that slot 0
        // outlives any age. Later rows cover the local id load and release, expiry
        // zero and its maximum, and ages that wrap across the 32-bit time.
        dir_rows = '{
            '{ROW_REQ,    32'h0000_0000, 32'h0000_0000, 1'b1, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_7FFF, 32'h0000_0005, 1'b1, 3'd1, 1'b0},
            '{ROW_REQ,    32'h0000_0000, 32'h0000_000A, 1'b1, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_7FFF, 32'h0000_000F, 1'b1, 3'd1, 1'b0},
            '{ROW_REQ,    32'h0000_0005, 32'h0000_001A, 1'b1, 3'd1, 1'b0},
            '{ROW_REQ,    32'h0000_0002, 32'h0000_001A, 1'b1, 3'd2, 1'b0},
            '{ROW_REQ,    32'h0000_0003, 32'h0000_001A, 1'b1, 3'd3, 1'b0},
            '{ROW_REQ,    32'h0000_0004, 32'h0000_001A, 1'b1, 3'd4, 1'b0},
            '{ROW_REQ,    32'h0000_0006, 32'h0000_001A, 1'b1, 3'd5, 1'b0},
            '{ROW_REQ,    32'h0000_0007, 32'h0000_001A, 1'b1, 3'd6, 1'b0},
            '{ROW_REQ,    32'h0000_0008, 32'h0000_001A, 1'b1, 3'd7, 1'b0},
            '{ROW_REQ,    32'h0000_0009, 32'h0000_001A, 1'b1, 3'd0, 1'b1},
            '{ROW_REQ,    32'h0000_0000, 32'h8000_0000, 1'b1, 3'd0, 1'b0},
            '{ROW_EXPIRY, 32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
            '{ROW_LOCAL,  32'h0000_1234, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_1234, 32'h8000_0000, 1'b1, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_2AAA, 32'h8000_0000, 1'b0, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_5555, 32'h8000_0001, 1'b0, 3'd0, 1'b0},
            '{ROW_LOCAL,  32'h0000_8000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
            '{ROW_EXPIRY, 32'h0000_FFFF, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_1234, 32'hFFFF_FFFF, 1'b1, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_0001, 32'hFFFF_FFF0, 1'b1, 3'd1, 1'b0},
            '{ROW_REQ,    32'h0000_0001, 32'h0000_0005, 1'b1, 3'd1, 1'b0},
            '{ROW_REQ,    32'h0000_0001, 32'h0001_0006, 1'b1, 3'd1, 1'b0},
            '{ROW_LOCAL,  32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0},
            '{ROW_REQ,    32'h0000_0000, 32'h0000_0000, 1'b0, 3'd0, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_REQ: begin
                    send_request(dir_rows[r].arg[ID_W-1:0], dir_rows[r].now,
                                 dir_rows[r].known,
                                 '{slot: dir_rows[r].slot, no_slot: dir_rows[r].no_slot});
                    maybe_idle(1'b1);
                end
                ROW_LOCAL: begin
                    drain_results();
                    reg_write(ADDR_LOCAL_ID, dir_rows[r].arg);
                end
                default: begin
                    drain_results();
                    reg_write(ADDR_EXPIRY, dir_rows[r].arg);
                end
            endcase
        end

        // Random phases, each under its own register setting. Requests draw their
        // ids from a small pool so that matches, refreshes, aging and a full table
        // all occur; time mostly creeps forward, sometimes steps right at the expiry
        // boundary, and now and then jumps anywhere. A few beats are pure noise.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    new_local  = $urandom_range(0, 32767);
                    new_expiry = 32'd10;
                end
                1: begin
                    new_local  = 32'h0000_8000;
                    new_expiry = 32'd0;
                end
                2: begin
                    new_local  = 32'h0000_0000;
                    new_expiry = 32'h0000_FFFF;
                end
                3: begin
                    new_local  = 32'h0000_7FFF;
                    new_expiry = 32'd1;
                end
                4: begin
                    new_local  = $urandom_range(0, 65535);
                    new_expiry = $urandom_range(0, 65535);
                end
                5: begin
                    new_local  = $urandom_range(0, 32767);
                    new_expiry = $urandom_range(2, 30);
                end
                default: begin
                    new_local  = 32'h0000_FFFF;
                    new_expiry = 32'd5;
                end
            endcase
            reg_write(ADDR_EXPIRY, new_expiry);
            reg_write(ADDR_LOCAL_ID, new_local);

            pool_n = $urandom_range(4, 14);
            for (int k = 0; k < pool_n; k++) begin
                id_pool[k] = ID_W'($urandom_range(0, 32767));
            end
            // Keep the local id in play so slot 0 sees matches.
            if (!local_id_reg[15]) begin
                id_pool[0] = local_id_reg[ID_W-1:0];
            end
            cur_now = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    id  = ID_W'($urandom_range(0, 32767));
                    now = $urandom;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        step = $urandom_range(0, 2);
                    end else if (pick < 85) begin
                        step = TIME_W'(expiry_reg) + $urandom_range(0, 1);
                    end else if (pick < 95) begin
                        step = $urandom_range(0, 40);
                    end else begin
                        step = $urandom;
                    end
                    cur_now = cur_now + step;
                    id      = id_pool[$urandom_range(0, pool_n - 1)];
                    now     = cur_now;
                end
                send_request(id, now, 1'b0, '0);
                // Once mid-run the sender waits for every grant before going on.
                // The final phase runs without any idling, and each phase has
                // stretches without it as well.
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end else begin
                    maybe_idle(p < PHASES - 1 && (n % 40) >= 10);
                end
            end
        end

        start <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: client_slot_table_with_aging.f
hdl/csta_pkg.sv
hdl/csta_cfg.sv
hdl/csta_scan.sv
hdl/client_slot_table_with_aging.sv
sim/tb_client_slot_table_with_aging.sv
